### hdl/bf_pkg.sv
// Shared types and constants for the Blowfish block engine.
// Used by every module under hdl/; depends on nothing.
`default_nettype none

package bf_pkg;

  localparam int BLOCK_W   = 64;
  localparam int HALF_W    = 32;
  localparam int IDX_W     = 10;
  localparam int CMD_W     = 2;
  localparam int BOXES     = 4;
  localparam int BOX_DEPTH = 256;
  localparam int BYTE_W    = 8;
  localparam int BOX_SEL_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENCRYPT = 2'd0,
    CMD_DECRYPT = 2'd1,
    CMD_LOAD_P  = 2'd2,
    CMD_LOAD_S  = 2'd3
  } cmd_e;

  // One beat moving down the round chain; loads travel with the blocks
  // so every cell sees table writes in stream order.
  typedef struct packed {
    logic              valid;
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [HALF_W-1:0] word;
    logic [HALF_W-1:0] lh;
    logic [HALF_W-1:0] rh;
  } bf_item_t;

endpackage

`default_nettype wire

### hdl/bf_round_cell.sv
// One Feistel round: private P keys, private copy of the four S-boxes.
// Three register stages. Depends on bf_pkg.
`default_nettype none

module bf_round_cell #(
  parameter int ENC_KEY = 0,
  parameter int DEC_KEY = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bf_pkg::bf_item_t  item_i,
  output bf_pkg::bf_item_t  item_o
);
  import bf_pkg::*;

  logic [HALF_W-1:0] p_enc_q;
  logic [HALF_W-1:0] p_dec_q;
  logic [HALF_W-1:0] sbox_mem [BOXES][BOX_DEPTH];
  logic [HALF_W-1:0] rd_q [BOXES];
  logic [HALF_W-1:0] t_q;
  logic [HALF_W-1:0] d_q;
  logic [HALF_W-1:0] x;
  logic              s_we;
  bf_item_t          s1_d;
  bf_item_t          s1_q;
  bf_item_t          s2_q;
  bf_item_t          out_d;
  bf_item_t          out_q;

  assign s_we = item_i.valid && (item_i.cmd == CMD_LOAD_S);

  // Key words for this round, captured as the load passes by
  always_ff @(posedge clk_i) begin
    if (item_i.valid && (item_i.cmd == CMD_LOAD_P) && (item_i.idx == IDX_W'(ENC_KEY))) begin
      p_enc_q <= item_i.word;
    end
    if (item_i.valid && (item_i.cmd == CMD_LOAD_P) && (item_i.idx == IDX_W'(DEC_KEY))) begin
      p_dec_q <= item_i.word;
    end
  end

  always_comb begin
    x = item_i.lh ^ ((item_i.cmd == CMD_DECRYPT) ? p_dec_q : p_enc_q);
    s1_d = item_i;
    s1_d.lh = x;
  end

  // Four 256-entry boxes, one write and one read port each
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < BOXES; b++) begin
      if (s_we && (item_i.idx[IDX_W-1 -: BOX_SEL_W] == BOX_SEL_W'(b))) begin
        sbox_mem[b][item_i.idx[BYTE_W-1:0]] <= item_i.word;
      end
      rd_q[b] <= sbox_mem[b][x[(BOXES-1-b)*BYTE_W +: BYTE_W]];
    end
  end

  always_ff @(posedge clk_i) begin
    t_q <= (rd_q[0] + rd_q[1]) ^ rd_q[2];
    d_q <= rd_q[3];
  end

  always_comb begin
    out_d = s2_q;
    out_d.lh = s2_q.rh ^ (t_q + d_q);
    out_d.rh = s2_q.lh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q  <= '0;
      s2_q  <= '0;
      out_q <= '0;
    end else begin
      s1_q  <= s1_d;
      s2_q  <= s1_q;
      out_q <= out_d;
    end
  end

  assign item_o = out_q;

endmodule

`default_nettype wire

### hdl/bf_whiten.sv
// Final cell: undo the last swap and apply the output whitening keys.
// Depends on bf_pkg.
`default_nettype none

module bf_whiten #(
  parameter int ROUNDS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bf_pkg::bf_item_t           item_i,
  output logic                       valid_o,
  output logic [bf_pkg::BLOCK_W-1:0] block_o
);
  import bf_pkg::*;

  logic [HALF_W-1:0]  p_r_enc_q;
  logic [HALF_W-1:0]  p_l_enc_q;
  logic [HALF_W-1:0]  p_r_dec_q;
  logic [HALF_W-1:0]  p_l_dec_q;
  logic               p_we;
  logic               is_block;
  logic               valid_q;
  logic [BLOCK_W-1:0] block_d;
  logic [BLOCK_W-1:0] block_q;

  assign p_we     = item_i.valid && (item_i.cmd == CMD_LOAD_P);
  assign is_block = (item_i.cmd == CMD_ENCRYPT) || (item_i.cmd == CMD_DECRYPT);

  always_ff @(posedge clk_i) begin
    if (p_we && (item_i.idx == IDX_W'(ROUNDS)))     p_r_enc_q <= item_i.word;
    if (p_we && (item_i.idx == IDX_W'(ROUNDS + 1))) p_l_enc_q <= item_i.word;
    if (p_we && (item_i.idx == IDX_W'(1)))          p_r_dec_q <= item_i.word;
    if (p_we && (item_i.idx == IDX_W'(0)))          p_l_dec_q <= item_i.word;
  end

  // Left comes from the right half of the last round and vice versa
  always_comb begin
    if (item_i.cmd == CMD_DECRYPT) begin
      block_d = {item_i.rh ^ p_l_dec_q, item_i.lh ^ p_r_dec_q};
    end else begin
      block_d = {item_i.rh ^ p_l_enc_q, item_i.lh ^ p_r_enc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= item_i.valid && is_block;
    end
  end

  always_ff @(posedge clk_i) begin
    block_q <= block_d;
  end

  assign valid_o = valid_q;
  assign block_o = block_q;

endmodule

`default_nettype wire

### hdl/bf_out_fifo.sv
// Result buffer between the free-running round chain and the output stream.
// Memory plus registered output beat. Depends on bf_pkg.
`default_nettype none

module bf_out_fifo #(
  parameter int AW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wr_valid_i,
  input  logic [bf_pkg::BLOCK_W-1:0] wr_data_i,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [bf_pkg::BLOCK_W-1:0] m_tdata_o
);
  import bf_pkg::*;

  localparam int DEPTH = 2 ** AW;

  logic [BLOCK_W-1:0] mem [DEPTH];
  logic [AW:0]        wptr_q;
  logic [AW:0]        rptr_q;
  logic               out_valid_q;
  logic [BLOCK_W-1:0] out_data_q;
  logic               empty;
  logic               pop;

  assign empty = (wptr_q == rptr_q);
  assign pop   = !empty && (!out_valid_q || m_tready_i);

  always_ff @(posedge clk_i) begin
    if (wr_valid_i) begin
      mem[wptr_q[AW-1:0]] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_data_q <= mem[rptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (wr_valid_i) wptr_q <= wptr_q + 1'b1;
      if (pop)        rptr_q <= rptr_q + 1'b1;
      out_valid_q <= pop || (out_valid_q && !m_tready_i);
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

`default_nettype wire

### hdl/blowfish_block_cipher.sv
// Blowfish ECB block engine: input register, chain of round cells, whitening
// cell and result buffer. Depends on bf_pkg, bf_round_cell, bf_whiten, bf_out_fifo.
//
// Usage:
//   Slave stream carries commands; tuser selects encrypt, decrypt, load P word
//   or load S-box word. Software loads all 18 P words and 1024 S words (index
//   box*256+entry) before sending blocks. Loads flow down the cell chain
//   behind earlier blocks, so each block sees exactly the tables written
//   before it. A P load with an index above 17 changes nothing.
//   Master stream returns one 64-bit block per encrypt or decrypt beat, in
//   order; loads return nothing.
// Timing:
//   An input beat reaches output tvalid through one input register, three stages
//   per round cell, one whitening stage, the buffer write and the output register.
//   One beat per cycle is accepted and returned, unless the matching tready is low.
//   Every round cell owns its own P keys and four 256x32 S-box RAMs.
// Stall:
//   The chain never stops. A credit count of blocks in flight against the
//   buffer depth (next power of two at or above 3*ROUNDS+6) drops s_axis_tready
//   only when the buffer could overflow; with tready held low the engine keeps
//   accepting until that many results wait.
// Reset: clear all valid flags and the credit count; tables hold garbage until loaded.
`default_nettype none

module blowfish_block_cipher #(
  parameter int ROUNDS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // slave stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [9:0] table_index, [41:10] table_word, [105:42] block_in, [111:106] zero
  input  logic [111:0]  s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]    s_axis_tuser,
  // master stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [63:0] block_out
  output logic [63:0]   m_axis_tdata
);
  import bf_pkg::*;

  localparam int FIFO_AW    = $clog2(3 * ROUNDS + 6);
  localparam int FIFO_DEPTH = 2 ** FIFO_AW;
  localparam int CNT_W      = FIFO_AW + 1;

  localparam int WORD_LSB  = IDX_W;
  localparam int BLOCK_LSB = IDX_W + HALF_W;

  bf_item_t           in_d;
  bf_item_t           in_q;
  bf_item_t           chain [ROUNDS+1];
  logic               res_valid;
  logic [BLOCK_W-1:0] res_block;
  logic [CNT_W-1:0]   cnt_q;
  logic               s_hs;
  logic               m_hs;
  logic               s_is_block;

  assign s_axis_tready = (cnt_q < CNT_W'(FIFO_DEPTH));
  assign s_hs          = s_axis_tvalid && s_axis_tready;
  assign m_hs          = m_axis_tvalid && m_axis_tready;
  assign s_is_block    = (cmd_e'(s_axis_tuser) == CMD_ENCRYPT) ||
                         (cmd_e'(s_axis_tuser) == CMD_DECRYPT);

  // Unpack the beat into a chain item; left half is the upper 32 bits
  always_comb begin
    in_d.valid = s_hs;
    in_d.cmd   = cmd_e'(s_axis_tuser);
    in_d.idx   = s_axis_tdata[IDX_W-1:0];
    in_d.word  = s_axis_tdata[WORD_LSB +: HALF_W];
    in_d.lh    = s_axis_tdata[BLOCK_LSB + HALF_W +: HALF_W];
    in_d.rh    = s_axis_tdata[BLOCK_LSB +: HALF_W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_q <= '0;
    end else begin
      in_q <= in_d;
    end
  end

  assign chain[0] = in_q;

  // Round r keys on P[r] for encrypt and P[ROUNDS+1-r] for decrypt
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    bf_round_cell #(
      .ENC_KEY (r),
      .DEC_KEY (ROUNDS + 1 - r)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .item_i (chain[r]),
      .item_o (chain[r+1])
    );
  end

  bf_whiten #(
    .ROUNDS (ROUNDS)
  ) u_whiten (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (chain[ROUNDS]),
    .valid_o (res_valid),
    .block_o (res_block)
  );

  bf_out_fifo #(
    .AW (FIFO_AW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (res_valid),
    .wr_data_i  (res_block),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

  // Credit count: blocks accepted whose result is not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      if ((s_hs && s_is_block) && !m_hs) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!(s_hs && s_is_block) && m_hs) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("credit count above buffer depth");

  a_out_has_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (cnt_q != '0))
    else $error("output beat without a block in flight");

  a_load_no_credit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_hs && !s_is_block && !m_hs) |=> $stable(cnt_q))
    else $error("load beat changed the credit count");
`endif

endmodule

`default_nettype wire
